@@ rtl/pkmp_pkg.sv @@
// Package for the parallel keyboard/mouse packetizer: payload structs,
// front-to-back command struct, phase codes, register indexes and step codes.
// No dependencies.
package pkmp_pkg;

   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 1;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_KBD_ENABLE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOUSE_ENABLE = 1'b1;

   localparam logic [3:0] BUTTON_NIBBLE = 4'h8;
   localparam logic [7:0] BUTTON_MARK   = 8'h80;

   // Back-end output steps: keyboard byte, then the five packet bytes.
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_KBD  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_BTN  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_DX   = 3'd2;
   localparam logic [STEP_W-1:0] STEP_DY   = 3'd3;
   localparam logic [STEP_W-1:0] STEP_PAD  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_LAST = 3'd5;

   typedef enum logic [2:0] {
      PH_DELY   = 3'b001,
      PH_BUTTON = 3'b010,
      PH_DELX   = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0] kbd_sample;
      logic [7:0] mouse_sample;
      logic       kbd_sink_ready;
      logic       mouse_sink_ready;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_source;
      logic       out_end_of_message;
      logic       out_end_of_item;
   } rsp_type;

   typedef struct packed {
      logic       has_kbd;
      logic [7:0] kbd_byte;
      logic       has_pkt;
      logic [7:0] btn;
      logic [7:0] dx;
      logic [7:0] dy;
   } cmd_type;

endpackage

@@ rtl/pkmp_front.sv @@
// Front end: takes requests, tracks port bytes and the mouse phase machine,
// and turns each emitting request into a back-end command. Uses pkmp_pkg.
module pkmp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [pkmp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pkmp_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  pkmp_pkg::req_type             req_payload,
   input  logic                          q_full,
   output logic                          q_push,
   output pkmp_pkg::cmd_type             q_data
);
   import pkmp_pkg::*;

   logic       kbd_en_ff, mouse_en_ff;
   logic [7:0] prev_kbd_ff, prev_kbd_in;
   logic [7:0] prev_mouse_ff, prev_mouse_in;
   phase_type  phase_ff, phase_in;
   logic [7:0] button_ff, button_in;
   logic [7:0] sent_ff, sent_in;
   logic [7:0] held_ff, held_in;

   logic       accept;
   logic       emit_kbd, emit_pkt;
   logic       is_btn;
   logic [7:0] ms, m;
   phase_type  eff_phase;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign ms        = req_payload.mouse_sample;
   assign is_btn    = (ms[7:4] == BUTTON_NIBBLE);
   assign m         = is_btn ? ms : {ms[7], ms[7:1]};

   always_comb begin
      prev_kbd_in   = req_payload.kbd_sample;
      prev_mouse_in = ms;
      phase_in      = phase_ff;
      button_in     = button_ff;
      sent_in       = sent_ff;
      held_in       = held_ff;
      emit_pkt      = 1'b0;
      eff_phase     = phase_ff;
      emit_kbd      = (req_payload.kbd_sample != prev_kbd_ff) && kbd_en_ff
                      && req_payload.kbd_sink_ready;
      if ((ms != prev_mouse_ff) && mouse_en_ff) begin
         if (is_btn) begin
            button_in = BUTTON_MARK | {5'b0, ms[3:1]};
            eff_phase = PH_BUTTON;
         end
         unique case (eff_phase)
            PH_BUTTON: begin
               phase_in = PH_DELX;
            end
            PH_DELX: begin
               phase_in = PH_DELY;
               if (!(button_in == sent_ff && m == 8'd0 && held_ff == 8'd0)) begin
                  sent_in  = button_in;
                  emit_pkt = req_payload.mouse_sink_ready;
                  held_in  = m;
               end
            end
            default: begin
               phase_in = PH_DELY;
               held_in  = m;
            end
         endcase
      end
   end

   assign q_push        = accept && (emit_kbd || emit_pkt);
   assign q_data.has_kbd  = emit_kbd;
   assign q_data.kbd_byte = req_payload.kbd_sample;
   assign q_data.has_pkt  = emit_pkt;
   assign q_data.btn      = button_in;
   assign q_data.dx       = m;
   assign q_data.dy       = held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kbd_en_ff     <= 1'b0;
         mouse_en_ff   <= 1'b0;
         prev_kbd_ff   <= 8'd0;
         prev_mouse_ff <= 8'd0;
         phase_ff      <= PH_DELY;
         button_ff     <= 8'd0;
         sent_ff       <= 8'd0;
         held_ff       <= 8'd0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_KBD_ENABLE:   kbd_en_ff   <= csr_wdata[0];
               CSR_MOUSE_ENABLE: mouse_en_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (accept) begin
            prev_kbd_ff   <= prev_kbd_in;
            prev_mouse_ff <= prev_mouse_in;
            phase_ff      <= phase_in;
            button_ff     <= button_in;
            sent_ff       <= sent_in;
            held_ff       <= held_in;
         end
      end
   end

endmodule

@@ rtl/pkmp_queue.sv @@
// Short command queue between the front and back ends.
// Uses pkmp_pkg for the command struct.
module pkmp_queue #(
   parameter int DEPTH = pkmp_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pkmp_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output pkmp_pkg::cmd_type head
);
   import pkmp_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/pkmp_back.sv @@
// Back end: serializes one command into its keyboard byte and packet bytes,
// one response per cycle while rsp_stall is low. Uses pkmp_pkg.
module pkmp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  pkmp_pkg::cmd_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pkmp_pkg::rsp_type rsp_payload
);
   import pkmp_pkg::*;

   logic                busy_ff, busy_in;
   cmd_type             cmd_ff;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                fire, last;

   assign rsp_valid = busy_ff;
   assign fire      = busy_ff && !rsp_stall;
   assign last      = (step_ff == (cmd_ff.has_pkt ? STEP_LAST : STEP_KBD));
   assign pop       = head_valid && (!busy_ff || (fire && last));

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (pop) begin
         busy_in = 1'b1;
         step_in = head.has_kbd ? STEP_KBD : STEP_BTN;
      end else if (fire) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_comb begin
      case (step_ff)
         STEP_KBD: rsp_payload.out_byte = cmd_ff.kbd_byte;
         STEP_BTN: rsp_payload.out_byte = cmd_ff.btn;
         STEP_DX:  rsp_payload.out_byte = cmd_ff.dx;
         STEP_DY:  rsp_payload.out_byte = cmd_ff.dy;
         STEP_PAD, STEP_LAST: rsp_payload.out_byte = 8'd0;
         default:  rsp_payload.out_byte = 8'd0;
      endcase
      rsp_payload.out_source         = (step_ff != STEP_KBD);
      rsp_payload.out_end_of_message = (step_ff == STEP_KBD) || (step_ff == STEP_LAST);
      rsp_payload.out_end_of_item    = last;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_KBD;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

endmodule

@@ rtl/parallel_kbd_mouse_packetizer.sv @@
// Parallel keyboard/mouse packetizer: request channel of port samples,
// response channel of emitted bytes, plain register write port.
// Uses pkmp_pkg, pkmp_front, pkmp_queue and pkmp_back.
//
// Each request carries one sample of the keyboard and mouse port bytes plus
// the two sink-ready flags. A keyboard change may yield one byte; a delta-X
// sample may yield a five-byte packet (button, dx, dy, 0, 0). A request
// yields zero to six responses; the last one carries out_end_of_item.
// The front end takes one request per cycle while the command queue
// (QUEUE_DEPTH entries) has room; req_stall is high only when it is full.
// The back end sends one response per cycle while rsp_stall is low; a
// request that yields nothing pushes no command and never reaches it.
// With the queue empty and the back end idle, an accepted request is
// written into the queue and then loaded into the back end before its
// first response is valid. A stalled response holds its payload; the
// front end keeps taking requests until the queue fills.
// Reset (synchronous, active high) clears both enables, the tracked port
// bytes, the phase machine and the queue. Write csr registers only while idle.
module parallel_kbd_mouse_packetizer #(
   parameter int QUEUE_DEPTH = pkmp_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [pkmp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pkmp_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pkmp_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pkmp_pkg::rsp_type               rsp_payload
);
   import pkmp_pkg::*;

   logic    q_full, q_push, q_pop, q_head_valid;
   cmd_type q_data, q_head;

   pkmp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_data)
   );

   pkmp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   pkmp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_head_valid),
      .head        (q_head),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // keyboard bytes always close their message
   a_kbd_eom: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.out_source) |-> rsp_payload.out_end_of_message)
      else $error("keyboard response without end of message");

   // a packet is always the tail of a request's responses
   a_pkt_eoi: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.out_source && rsp_payload.out_end_of_message)
      |-> rsp_payload.out_end_of_item)
      else $error("packet end not at end of item");

   // responses of one request come without gaps
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_payload.out_end_of_item) |=> rsp_valid)
      else $error("gap inside a request's responses");

   a_mouse_eoi_eom: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.out_source && rsp_payload.out_end_of_item)
      |-> rsp_payload.out_end_of_message)
      else $error("mouse item ends mid-packet");

endmodule
